// ----- rtl/double_ended_queue_core_assert.svh -----
// assertion macros for the double-ended queue checker
// needs clk_i and rst_ni in the scope that uses them
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define DQC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DQC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dqc_pkg.sv -----
`timescale 1ns / 1ps
// shared types and codes of the double-ended queue core
// no dependencies
package dqc_pkg;

  localparam int DATA_W = 32;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_LIST_FWD   = 3'd4;
  localparam logic [2:0] REQ_LIST_BWD   = 3'd5;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_LOAD
  } cell_sel_e;

endpackage

// ----- rtl/double_ended_queue_core.sv -----
`timescale 1ns / 1ps
// double-ended queue core: a chain of storage cells, the front held in cell 0
// push and pop: result in the next cycle; one transaction per cycle while in_stall_o is low
// listing: one chain rotation per emitted entry; empty listing as a pop
// reset clears occupancy, listing control and the output register; cell contents stay undefined
// uses dqc_pkg and dqc_cell
module double_ended_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] item_value_o,
  output logic               last_o
);

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int DW    = dqc_pkg::DATA_W;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_e;

  state_e             state_q;
  logic [OCC_W-1:0]   occ_q;
  logic [OCC_W-1:0]   cnt_q;
  logic               bwd_q;
  logic               out_valid_q;
  logic [1:0]         status_q;
  logic [DW-1:0]      item_q;
  logic               last_q;

  logic               out_free;
  logic               accept;
  logic               full;
  logic               empty;
  logic               step;
  logic               list_last;
  logic               out_load;
  logic               do_push_f;
  logic               do_push_b;
  logic               do_pop_f;
  logic               step_fwd;
  logic               step_bwd;
  logic [DW-1:0]      head;
  logic [DW-1:0]      tail;
  logic [DW-1:0]      load_bus;
  logic [DW-1:0]      cell_data [QUEUE_DEPTH];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (occ_q == OCC_W'(QUEUE_DEPTH));
  assign empty      = (occ_q == '0);
  assign step       = (state_q == ST_LIST) && out_free;
  assign list_last  = ((cnt_q + OCC_W'(1)) == occ_q);

  assign out_load = step ||
                    (accept && (req_type_i inside {dqc_pkg::REQ_PUSH_FRONT,
                                                   dqc_pkg::REQ_PUSH_BACK,
                                                   dqc_pkg::REQ_POP_FRONT,
                                                   dqc_pkg::REQ_POP_BACK})) ||
                    (accept && empty &&
                     (req_type_i inside {dqc_pkg::REQ_LIST_FWD, dqc_pkg::REQ_LIST_BWD}));

  assign do_push_f = accept && (req_type_i == dqc_pkg::REQ_PUSH_FRONT) && !full;
  assign do_push_b = accept && (req_type_i == dqc_pkg::REQ_PUSH_BACK) && !full;
  assign do_pop_f  = accept && (req_type_i == dqc_pkg::REQ_POP_FRONT) && !empty;
  assign step_fwd  = step && !bwd_q;
  assign step_bwd  = step && bwd_q;

  assign head     = cell_data[0];
  assign load_bus = step ? head : push_value_i;

  always_comb begin
    tail = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (occ_q == OCC_W'(i + 1)) begin
        tail = tail | cell_data[i];
      end
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [DW-1:0]      left_in;
    logic [DW-1:0]      right_in;
    logic               is_end;
    logic               is_slot;
    logic               in_body;
    dqc_pkg::cell_sel_e sel;

    assign is_end  = (occ_q == OCC_W'(g + 1));
    assign is_slot = (occ_q == OCC_W'(g));
    assign in_body = (OCC_W'(g + 1) < occ_q);

    if (g == 0) begin : g_first
      assign left_in = step_bwd ? tail : push_value_i;
    end else begin : g_mid
      assign left_in = cell_data[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign right_in = cell_data[g];
    end else begin : g_inner
      assign right_in = cell_data[g+1];
    end

    always_comb begin
      sel = dqc_pkg::CELL_HOLD;
      if (do_push_f || step_bwd) begin
        sel = dqc_pkg::CELL_LEFT;
      end else if (do_pop_f) begin
        sel = dqc_pkg::CELL_RIGHT;
      end else if (do_push_b && is_slot) begin
        sel = dqc_pkg::CELL_LOAD;
      end else if (step_fwd && is_end) begin
        sel = dqc_pkg::CELL_LOAD;
      end else if (step_fwd && in_body) begin
        sel = dqc_pkg::CELL_RIGHT;
      end
    end

    dqc_cell u_cell (
      .clk_i   (clk_i),
      .sel_i   (sel),
      .left_i  (left_in),
      .right_i (right_in),
      .load_i  (load_bus),
      .data_o  (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      cnt_q       <= '0;
      bwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= dqc_pkg::STATUS_OK;
      item_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (req_type_i)
              dqc_pkg::REQ_PUSH_FRONT, dqc_pkg::REQ_PUSH_BACK: begin
                item_q      <= '0;
                last_q      <= 1'b1;
                if (full) begin
                  status_q <= dqc_pkg::STATUS_FULL;
                end else begin
                  status_q <= dqc_pkg::STATUS_OK;
                  occ_q    <= occ_q + OCC_W'(1);
                end
              end
              dqc_pkg::REQ_POP_FRONT, dqc_pkg::REQ_POP_BACK: begin
                item_q      <= '0;
                last_q      <= 1'b1;
                if (empty) begin
                  status_q <= dqc_pkg::STATUS_EMPTY;
                end else begin
                  status_q <= dqc_pkg::STATUS_OK;
                  occ_q    <= occ_q - OCC_W'(1);
                end
              end
              dqc_pkg::REQ_LIST_FWD, dqc_pkg::REQ_LIST_BWD: begin
                if (empty) begin
                  status_q    <= dqc_pkg::STATUS_EMPTY;
                  item_q      <= '0;
                  last_q      <= 1'b1;
                end else begin
                  state_q <= ST_LIST;
                  cnt_q   <= '0;
                  bwd_q   <= (req_type_i == dqc_pkg::REQ_LIST_BWD);
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_LIST: begin
          if (out_free) begin
            status_q    <= dqc_pkg::STATUS_OK;
            item_q      <= bwd_q ? tail : head;
            last_q      <= list_last;
            cnt_q       <= cnt_q + OCC_W'(1);
            if (list_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign item_value_o = item_q;
  assign last_o       = last_q;

endmodule

// ----- rtl/dqc_cell.sv -----
`timescale 1ns / 1ps
// one storage cell of the queue chain
// uses dqc_pkg for the select code and data width
module dqc_cell (
  input  logic                          clk_i,
  input  dqc_pkg::cell_sel_e            sel_i,
  input  logic [dqc_pkg::DATA_W-1:0]    left_i,
  input  logic [dqc_pkg::DATA_W-1:0]    right_i,
  input  logic [dqc_pkg::DATA_W-1:0]    load_i,
  output logic [dqc_pkg::DATA_W-1:0]    data_o
);

  logic [dqc_pkg::DATA_W-1:0] data_q;
  logic [dqc_pkg::DATA_W-1:0] data_d;

  always_comb begin
    case (sel_i)
      dqc_pkg::CELL_HOLD:  data_d = data_q;
      dqc_pkg::CELL_LEFT:  data_d = left_i;
      dqc_pkg::CELL_RIGHT: data_d = right_i;
      dqc_pkg::CELL_LOAD:  data_d = load_i;
      default:             data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- rtl/dqc_checker.sv -----
`timescale 1ns / 1ps
// port-level checks of the double-ended queue core, bound to the top level
// uses dqc_pkg and double_ended_queue_core_assert.svh
`include "double_ended_queue_core_assert.svh"

module dqc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [2:0]  req_type_i,
  input logic [31:0] push_value_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [31:0] item_value_o,
  input logic        last_o
);

  logic in_xact;
  logic single_req;

  assign in_xact    = in_valid_i && !in_stall_o;
  assign single_req = (req_type_i == dqc_pkg::REQ_PUSH_FRONT) ||
                      (req_type_i == dqc_pkg::REQ_PUSH_BACK) ||
                      (req_type_i == dqc_pkg::REQ_POP_FRONT) ||
                      (req_type_i == dqc_pkg::REQ_POP_BACK);

  `DQC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(item_value_o) && $stable(status_o) && $stable(last_o), "stalled result changed")
  `DQC_ASSERT_NEXT(a_single_result, in_xact && single_req, out_valid_o && last_o && (item_value_o == 32'd0), "push or pop gave no single result")
  `DQC_ASSERT_NOW(a_status_zero, out_valid_o && (status_o != dqc_pkg::STATUS_OK), last_o && (item_value_o == 32'd0), "status result carries a value")
  `DQC_ASSERT_NOW(a_list_busy, out_valid_o && !last_o, in_stall_o, "transaction taken during a listing")

endmodule

bind double_ended_queue_core dqc_checker u_dqc_checker (.*);
